// ===== design/mtg_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and word functions of the MT19937 generator.
package mtg_pkg;

  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned SHIFT_OFFSET = 397;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned IDX_W        = $clog2(STATE_WORDS);

  localparam logic [IDX_W-1:0]  LAST_IDX     = IDX_W'(STATE_WORDS - 1);
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] SEED_RESET   = 32'd5489;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  seed_idx_t;

  // Taps of the cell row: oldest word, its neighbour, the far word, newest word.
  typedef struct packed {
    word_t head;
    word_t next;
    word_t far;
    word_t tail;
  } mtg_taps_t;

  function automatic word_t twist_word(input word_t head, input word_t next,
                                       input word_t far);
    word_t y;
    y = (head & HIGH_BIT) | (next & LOW_BITS);
    return far ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);
  endfunction

  function automatic word_t seed_word(input word_t prev, input seed_idx_t idx);
    word_t p;
    p = SEED_MULT * (prev ^ (prev >> 30));
    return p + WORD_W'(idx);
  endfunction

  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== design/mtg_req_if.sv =====
`timescale 1ns / 1ps
// Request channel: valid, ready and the restart flag.
interface mtg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// ===== design/mtg_word_if.sv =====
`timescale 1ns / 1ps
// Result channel: valid, ready and the tempered random word.
interface mtg_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

// ===== design/mtg_cell.sv =====
`timescale 1ns / 1ps
// One state cell: a 32-bit word register that loads its input d (the neighbour's word, or the new word) on shift.
module mtg_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  mtg_pkg::word_t d,
  output mtg_pkg::word_t q
);
  import mtg_pkg::*;

  word_t word_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      word_r <= d;
    end
  end

  assign q = word_r;

endmodule

// ===== design/mtg_cell_row.sv =====
`timescale 1ns / 1ps
// Row of state cells forming the circular window of the twister sequence.
module mtg_cell_row (
  input  logic              clk,
  input  logic              shift_en,
  input  mtg_pkg::word_t    new_word,
  output mtg_pkg::mtg_taps_t taps
);
  import mtg_pkg::*;

  word_t q [STATE_WORDS];

  // Cell 0 holds the oldest word; the newest word enters at the far end.
  for (genvar k = 0; k < STATE_WORDS; k++) begin : g_cell
    if (k == STATE_WORDS - 1) begin : g_last
      mtg_cell u_cell (.clk(clk), .shift_en(shift_en), .d(new_word), .q(q[k]));
    end else begin : g_mid
      mtg_cell u_cell (.clk(clk), .shift_en(shift_en), .d(q[k+1]), .q(q[k]));
    end
  end

  assign taps.head = q[0];
  assign taps.next = q[1];
  assign taps.far  = q[SHIFT_OFFSET];
  assign taps.tail = q[STATE_WORDS-1];

endmodule

// ===== design/mersenne_twister_generator_unit.sv =====
`timescale 1ns / 1ps
// Top level of the MT19937 generator: request control, seeding and output register.
//
// Usage: each word accepted on in_ch asks for one tempered 32-bit word on out_ch.
// The 624 state words sit in a row of cells that shifts by one per generated word;
// the new word is twisted from the oldest word, its neighbour and the word 397 on.
// A request with restart set, or the first request after reset, rebuilds the
// state from the seed register first: the seed word itself enters, then one word
// per cycle through the seed multiplier, with in_ch.ready held low meanwhile.
// A normal request shows its word on out_ch in the cycle after acceptance; a
// reseeding request passes through ST_SEED and ST_EMIT before its word is shown.
// Throughput: one word per cycle while out_ch takes every word; a rebuild holds
// in_ch.ready low through ST_SEED and ST_EMIT, until its word is emitted.
// cfg_wr_en writes cfg_wr_data to the seed register; writing it does not reseed.
// Reset: seed register returns to 5489, the generator is unseeded and out_ch is
// empty; the state words are left as they are until the next seeding.
// Stall: a word not taken is held in the output register, and a new request is
// accepted only in the cycle that word leaves or once the register is empty.
module mersenne_twister_generator_unit (
  input  logic          clk,
  input  logic          rst_n,
  mtg_req_if.sink       in_ch,
  mtg_word_if.source    out_ch,
  input  logic          cfg_wr_en,
  input  mtg_pkg::word_t cfg_wr_data
);
  import mtg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_EMIT
  } state_t;

  state_t    state_r;
  seed_idx_t seed_idx_r;
  logic      seeded_r;
  logic      out_valid_r;
  word_t     out_word_r;
  word_t     seed_r;

  mtg_taps_t taps;
  word_t     twisted;
  word_t     new_word;
  logic      shift_en;
  logic      out_free;
  logic      in_fire;
  logic      need_seed;
  logic      emit;

  mtg_cell_row u_row (
    .clk      (clk),
    .shift_en (shift_en),
    .new_word (new_word),
    .taps     (taps)
  );

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign need_seed = in_ch.restart || !seeded_r;
  assign twisted   = twist_word(taps.head, taps.next, taps.far);

  assign emit = (in_fire && !need_seed) || ((state_r == ST_EMIT) && out_free);

  always_comb begin
    if (state_r == ST_SEED) begin
      new_word = (seed_idx_r == '0) ? seed_r : seed_word(taps.tail, seed_idx_r);
    end else begin
      new_word = twisted;
    end
  end

  assign shift_en = emit || (state_r == ST_SEED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_idx_r  <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        out_word_r  <= temper(twisted);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire && need_seed) begin
            state_r    <= ST_SEED;
            seed_idx_r <= '0;
          end
        end
        ST_SEED: begin
          // advance through the seed recurrence, one cell per cycle
          if (seed_idx_r == LAST_IDX) begin
            state_r  <= ST_EMIT;
            seeded_r <= 1'b1;
          end else begin
            seed_idx_r <= seed_idx_r + 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.random_word = out_word_r;

  a_reseed_enters_seed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && need_seed) |=> (state_r == ST_SEED))
    else $error("reseeding request did not start seeding");

  a_plain_request_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !need_seed) |=> out_valid_r)
    else $error("seeded request produced no word");

  a_seed_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEED) |-> (seed_idx_r <= LAST_IDX))
    else $error("seed index past last cell");

  a_seeded_stays: assert property (@(posedge clk) disable iff (!rst_n)
    seeded_r |=> seeded_r)
    else $error("seeded flag dropped without reset");

endmodule
